FILE: rtl/sarc_pkg.sv
// Shared types and constants for the set-associative row cache tag controller.
// No dependencies.
package sarc_pkg;

   localparam int KEY_W   = 57;
   localparam int STAMP_W = 48;
   localparam int ID_W    = 41;
   localparam int TAG_W   = 56;
   localparam int NSET_W  = 13;
   localparam int RC_W    = 3;
   localparam int SETO_W  = 12;
   localparam int WAYO_W  = 3;
   localparam int KCNT_W  = 6;

   localparam logic [NSET_W-1:0] NSET_RESET = 13'd4096;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_FILL   = 1'b1;

   localparam logic [RC_W-1:0] RC_HIT      = 3'd0;
   localparam logic [RC_W-1:0] RC_MISS     = 3'd1;
   localparam logic [RC_W-1:0] RC_RANGE    = 3'd2;
   localparam logic [RC_W-1:0] RC_FILL_NEW = 3'd3;
   localparam logic [RC_W-1:0] RC_REPLACE  = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/sarc_req_if.sv
// Request channel: valid/ready handshake plus one lookup or fill beat.
// Depends on sarc_pkg.
interface sarc_req_if;
   import sarc_pkg::*;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic              first_of_request;
   logic [ID_W-1:0]   row_id;
   logic [TAG_W-1:0]  table_tag;
   logic [ID_W-1:0]   table_rows;
   modport source (output valid, opcode, first_of_request, row_id, table_tag, table_rows,
                   input ready);
   modport sink   (input valid, opcode, first_of_request, row_id, table_tag, table_rows,
                   output ready);
endinterface

FILE: rtl/sarc_rsp_if.sv
// Response channel: valid/ready handshake plus one result beat.
// Depends on sarc_pkg.
interface sarc_rsp_if;
   import sarc_pkg::*;
   logic              valid;
   logic              ready;
   logic [RC_W-1:0]   result_code;
   logic [SETO_W-1:0] set_index;
   logic [WAYO_W-1:0] way_index;
   modport source (output valid, result_code, set_index, way_index, input ready);
   modport sink   (input valid, result_code, set_index, way_index, output ready);
endinterface

FILE: rtl/set_assoc_row_cache_tags.sv
// Tag and replacement controller for a WAYS-way set-associative row cache.
// Depends on sarc_pkg, sarc_req_if, sarc_rsp_if.
//
// One beat is handled at a time. After reset the block sweeps its tag memories,
// one set per cycle, through all NUM_SETS_MAX sets (4096 by default) and takes
// no beat until done; csr writes are taken at any time. A beat then passes
// through restoring remainder (key mod num_sets, one key bit per cycle), a
// memory read, the way scan (one way compared per cycle), a write-back and a
// response, plus any response stall. A lookup whose row id is out of range
// skips all of that and answers in the cycle after it is taken. After each
// response the block returns to idle before it takes the next beat, so a new
// beat is not taken until the last one is answered. num_sets of 0 acts as 1,
// values above NUM_SETS_MAX act as NUM_SETS_MAX. The request clock is 48 bits
// and advances on a lookup flagged first_of_request, even one out of range.
module set_assoc_row_cache_tags #(
   parameter int NUM_SETS_MAX = 4096,
   parameter int WAYS         = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   sarc_req_if.sink                     req,
   sarc_rsp_if.source                   rsp,
   input  logic                         csr_wr_en,
   input  logic [sarc_pkg::NSET_W-1:0]  csr_wr_data
);
   import sarc_pkg::*;

   localparam int SET_W = (NUM_SETS_MAX > 1) ? $clog2(NUM_SETS_MAX) : 1;
   localparam int DIV_W = $clog2(NUM_SETS_MAX + 1);
   localparam int WAY_W = $clog2(WAYS);

   // tag memories, one row per set
   logic [WAYS-1:0]                vmem [NUM_SETS_MAX];
   logic [WAYS-1:0][STAMP_W-1:0]   smem [NUM_SETS_MAX];
   logic [WAYS-1:0][KEY_W-1:0]     kmem [NUM_SETS_MAX];

   logic [WAYS-1:0]                rdv_ff;
   logic [WAYS-1:0][STAMP_W-1:0]   rds_ff;
   logic [WAYS-1:0][KEY_W-1:0]     rdk_ff;

   state_type state_ff, state_in;

   logic [NSET_W-1:0]  nsets_ff;
   logic [STAMP_W-1:0] clk_ff, clk_in;
   logic [SET_W-1:0]   clr_ff, clr_in;

   logic               op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [KCNT_W-1:0]  kcnt_ff, kcnt_in;
   logic [SET_W-1:0]   set_ff, set_in;

   logic [WAY_W-1:0]   wcnt_ff, wcnt_in;
   logic               mfound_ff, mfound_in;
   logic [WAY_W-1:0]   mway_ff, mway_in;
   logic               ifound_ff, ifound_in;
   logic [WAY_W-1:0]   iway_ff, iway_in;
   logic [WAY_W-1:0]   bway_ff, bway_in;
   logic [STAMP_W-1:0] bstamp_ff, bstamp_in;

   logic [RC_W-1:0]    code_ff, code_in;
   logic [SETO_W-1:0]  oset_ff, oset_in;
   logic [WAYO_W-1:0]  oway_ff, oway_in;

   // effective divisor
   logic [DIV_W-1:0]   div_val;
   logic [DIV_W:0]     rem_sh;
   logic [KEY_W-1:0]   id_ext;
   logic               in_range;
   logic [WAY_W-1:0]   fway;

   logic               wr_en;
   logic [SET_W-1:0]   wr_addr;
   logic [WAYS-1:0]    wr_v;
   logic [WAYS-1:0][STAMP_W-1:0] wr_s;
   logic [WAYS-1:0][KEY_W-1:0]   wr_k;

   always_comb begin
      if (nsets_ff == '0) begin
         div_val = DIV_W'(1);
      end else if (int'(nsets_ff) > NUM_SETS_MAX) begin
         div_val = DIV_W'(NUM_SETS_MAX);
      end else begin
         div_val = DIV_W'(nsets_ff);
      end
   end

   assign rem_sh   = {rem_ff, key_ff[kcnt_ff]};
   assign id_ext   = {{(KEY_W-ID_W){req.row_id[ID_W-1]}}, req.row_id};
   assign in_range = !req.row_id[ID_W-1] && (req.row_id < req.table_rows);
   assign fway     = mfound_ff ? mway_ff : (ifound_ff ? iway_ff : bway_ff);

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = (state_ff == ST_RESP);
   assign rsp.result_code = code_ff;
   assign rsp.set_index   = oset_ff;
   assign rsp.way_index   = oway_ff;

   always_comb begin
      state_in  = state_ff;
      clk_in    = clk_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      rem_in    = rem_ff;
      kcnt_in   = kcnt_ff;
      set_in    = set_ff;
      wcnt_in   = wcnt_ff;
      mfound_in = mfound_ff;
      mway_in   = mway_ff;
      ifound_in = ifound_ff;
      iway_in   = iway_ff;
      bway_in   = bway_ff;
      bstamp_in = bstamp_ff;
      code_in   = code_ff;
      oset_in   = oset_ff;
      oway_in   = oway_ff;
      wr_en     = 1'b0;
      wr_addr   = set_ff;
      wr_v      = rdv_ff;
      wr_s      = rds_ff;
      wr_k      = rdk_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_v    = '0;
            wr_s    = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SET_W'(NUM_SETS_MAX - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               op_in   = req.opcode;
               key_in  = id_ext + {1'b0, req.table_tag};
               rem_in  = '0;
               kcnt_in = KCNT_W'(KEY_W - 1);
               if (req.opcode == OP_LOOKUP && req.first_of_request) begin
                  clk_in = clk_ff + 1'b1;
               end
               if (req.opcode == OP_LOOKUP && !in_range) begin
                  code_in  = RC_RANGE;
                  oset_in  = '0;
                  oway_in  = '0;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (rem_sh >= {1'b0, div_val}) begin
               rem_in = DIV_W'(rem_sh - {1'b0, div_val});
            end else begin
               rem_in = DIV_W'(rem_sh);
            end
            kcnt_in = kcnt_ff - 1'b1;
            if (kcnt_ff == '0) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // set_in drives the read address; the row is there for the first scan
            set_in    = SET_W'(rem_ff);
            wcnt_in   = '0;
            mfound_in = 1'b0;
            ifound_in = 1'b0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (!mfound_ff && rdv_ff[wcnt_ff] && rdk_ff[wcnt_ff] == key_ff) begin
               mfound_in = 1'b1;
               mway_in   = wcnt_ff;
            end
            if (!ifound_ff && !rdv_ff[wcnt_ff]) begin
               ifound_in = 1'b1;
               iway_in   = wcnt_ff;
            end
            if (wcnt_ff == '0 || rds_ff[wcnt_ff] < bstamp_ff) begin
               bway_in   = wcnt_ff;
               bstamp_in = rds_ff[wcnt_ff];
            end
            wcnt_in = wcnt_ff + 1'b1;
            if (wcnt_ff == WAY_W'(WAYS - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            oset_in  = SETO_W'(set_ff);
            state_in = ST_RESP;
            if (op_ff == OP_LOOKUP) begin
               if (mfound_ff) begin
                  wr_en         = 1'b1;
                  wr_s[mway_ff] = clk_ff;
                  code_in       = RC_HIT;
                  oway_in       = WAYO_W'(mway_ff);
               end else begin
                  code_in = RC_MISS;
                  oway_in = '0;
               end
            end else begin
               wr_en      = 1'b1;
               wr_v[fway] = 1'b1;
               wr_s[fway] = clk_ff;
               wr_k[fway] = key_ff;
               code_in    = rdv_ff[fway] ? RC_REPLACE : RC_FILL_NEW;
               oway_in    = WAYO_W'(fway);
            end
         end
         ST_RESP: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         clk_ff   <= '0;
         nsets_ff <= NSET_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         clk_ff   <= clk_in;
         if (csr_wr_en) begin
            nsets_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      rem_ff    <= rem_in;
      kcnt_ff   <= kcnt_in;
      set_ff    <= set_in;
      wcnt_ff   <= wcnt_in;
      mfound_ff <= mfound_in;
      mway_ff   <= mway_in;
      ifound_ff <= ifound_in;
      iway_ff   <= iway_in;
      bway_ff   <= bway_in;
      bstamp_ff <= bstamp_in;
      code_ff   <= code_in;
      oset_ff   <= oset_in;
      oway_ff   <= oway_in;
   end

   // memories: one row write, one registered row read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vmem[wr_addr] <= wr_v;
         smem[wr_addr] <= wr_s;
         kmem[wr_addr] <= wr_k;
      end
      rdv_ff <= vmem[set_in];
      rds_ff <= smem[set_in];
      rdk_ff <= kmem[set_in];
   end

endmodule
